### rtl/msr_pkg.sv
// Shared types and constants for the modular square root block.
package msr_pkg;

   localparam int DATA_W = 32;
   localparam logic [63:0] NR_LIMIT = 64'd4096;

   typedef enum logic [1:0] {
      MM_MUL,
      MM_RED
   } mm_mode_type;

   typedef enum logic [5:0] {
      DP_NOP,
      DP_LOAD,
      DP_REDUCE,
      DP_POW_EULER,
      DP_POW_Q3,
      DP_POW_Q5,
      DP_POW_Q5R,
      DP_POW_Q5N,
      DP_POW_NR,
      DP_POW_INV,
      DP_POW_C,
      DP_POW_R,
      DP_MUL_YX,
      DP_MUL_XX,
      DP_MUL_A2,
      DP_MUL_A4,
      DP_MUL_GY,
      DP_MUL_RR,
      DP_MUL_DINV,
      DP_MUL_DD,
      DP_MUL_RC,
      DP_MUL_CC,
      DP_MOV_YR,
      DP_MOV_YINV,
      DP_MOV_YC,
      DP_SET_R0,
      DP_SET_R1,
      DP_SET_K2,
      DP_INC_K,
      DP_NR_FOUND,
      DP_T_SHIFT,
      DP_TS_START,
      DP_SET_N,
      DP_FIN_OK,
      DP_FIN_FAIL
   } dp_op_type;

   typedef enum logic [3:0] {
      DST_A,
      DST_X,
      DST_Y,
      DST_G,
      DST_F,
      DST_R,
      DST_D,
      DST_C
   } mul_dst_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic p_zero;
      logic p_one;
      logic p_two;
      logic p_odd;
      logic p_mod4_3;
      logic p_mod8_5;
      logic a_zero;
      logic a_one;
      logic y_one;
      logic y_pm1;
      logic d_pm1;
      logic d_eq_a;
      logic e_zero;
      logic e_lsb;
      logic t_even;
      logic n_zero;
      logic i_lt_s;
      logic k_over;
   } dp_status_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_START,
      ST_DISPATCH,
      ST_EULER_CHK,
      ST_Q3_DONE,
      ST_Q5_CHK,
      ST_Q5N_A4,
      ST_Q5N_POW,
      ST_Q5N_MUL,
      ST_NR_TEST,
      ST_NR_CHK,
      ST_TS_SHIFT,
      ST_TS_C,
      ST_TS_C2,
      ST_TS_R,
      ST_TS_R2,
      ST_TS_LOOP0,
      ST_TS_LOOP,
      ST_TS_DINV,
      ST_TS_CNT,
      ST_TS_SQ,
      ST_TS_CHK,
      ST_TS_CC,
      ST_VERIFY,
      ST_VERIFY_CHK,
      ST_POW,
      ST_POW_XX,
      ST_MUL_WAIT,
      ST_FIN_OK,
      ST_FIN_FAIL
   } state_type;

endpackage

### rtl/msr_modmul.sv
// Bit-serial modular multiplier and reducer.
module msr_modmul #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mm_start,
   input  msr_pkg::mm_mode_type      mm_mode,
   input  logic [WIDTH-1:0]          mm_x,
   input  logic [WIDTH-1:0]          mm_y,
   input  logic [WIDTH-1:0]          mm_m,
   output logic                      mm_done,
   output logic [WIDTH-1:0]          mm_result
);
   import msr_pkg::*;

   localparam int CW = $clog2(WIDTH);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              phase_ff, phase_in;
   mm_mode_type       mode_ff, mode_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WIDTH-1:0]  acc_ff, acc_in;
   logic [WIDTH-1:0]  x_ff, x_in;
   logic [WIDTH-1:0]  y_ff, y_in;
   logic [WIDTH-1:0]  m_ff, m_in;
   logic [WIDTH:0]    shifted, summed, operand, reduced;

   always_comb begin
      shifted = (mode_ff == MM_RED) ? {acc_ff, y_ff[WIDTH-1]} : {acc_ff, 1'b0};
      summed  = {1'b0, acc_ff} + {1'b0, x_ff};
      if (!phase_ff) begin
         operand = shifted;
      end else if (y_ff[WIDTH-1]) begin
         operand = summed;
      end else begin
         operand = {1'b0, acc_ff};
      end
      reduced = (operand >= {1'b0, m_ff}) ? operand - {1'b0, m_ff} : operand;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      m_in     = m_ff;
      if (mm_start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         mode_in  = mm_mode;
         cnt_in   = CW'(WIDTH - 1);
         acc_in   = '0;
         x_in     = mm_x;
         y_in     = mm_y;
         m_in     = mm_m;
      end else if (busy_ff) begin
         acc_in = reduced[WIDTH-1:0];
         if (mode_ff == MM_MUL && !phase_ff) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            y_in     = {y_ff[WIDTH-2:0], 1'b0};
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         mode_ff  <= MM_MUL;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign mm_done   = done_ff;
   assign mm_result = acc_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("modmul done while busy");
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      (done_ff && m_ff != '0) |-> (acc_ff < m_ff)) else $error("modmul result not reduced");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      mm_start |=> busy_ff) else $error("modmul did not start");

endmodule

### rtl/msr_datapath.sv
// Datapath: operand registers, modulus register, exponent setup and result packing.
module msr_datapath #(
   parameter int WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  msr_pkg::dp_cmd_type             cmd,
   output msr_pkg::dp_status_type          status,
   input  logic [msr_pkg::DATA_W-1:0]      req_data,
   input  logic                            csr_load,
   input  logic [msr_pkg::DATA_W-1:0]      csr_data,
   output logic                            out_has_root,
   output logic [msr_pkg::DATA_W-1:0]      out_small,
   output logic [msr_pkg::DATA_W-1:0]      out_large
);
   import msr_pkg::*;

   localparam int SW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] p_ff, p_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [WIDTH-1:0] c_ff, c_in;
   logic [WIDTH-1:0] inv_ff, inv_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] t_ff, t_in;
   logic [WIDTH-1:0] k_ff, k_in;
   logic [WIDTH-1:0] g_ff, g_in;
   logic [WIDTH-1:0] f_ff, f_in;
   logic [SW-1:0]    s_ff, s_in;
   logic [SW-1:0]    i_ff, i_in;
   logic [SW-1:0]    n_ff, n_in;
   mul_dst_type      dst_ff, dst_in;
   logic             has_ff, has_in;
   logic [DATA_W-1:0] small_ff, small_in;
   logic [DATA_W-1:0] large_ff, large_in;

   logic              mm_start, mm_done;
   mm_mode_type       mm_mode;
   logic [WIDTH-1:0]  mm_x, mm_y, mm_result;

   logic [WIDTH-1:0]  pm1, other, lo_root, hi_root;
   logic [WIDTH:0]    pp1, pp3, tp1;
   logic [63:0]       req_wide, csr_wide, lo_wide, hi_wide;

   always_comb begin
      pm1      = p_ff - 1'b1;
      pp1      = {1'b0, p_ff} + 1'b1;
      pp3      = {1'b0, p_ff} + (WIDTH+1)'(3);
      tp1      = {1'b0, t_ff} + 1'b1;
      req_wide = {32'b0, req_data};
      csr_wide = {32'b0, csr_data};
      other    = (r_ff == '0) ? '0 : p_ff - r_ff;
      lo_root  = (r_ff < other) ? r_ff : other;
      hi_root  = (r_ff < other) ? other : r_ff;
      lo_wide  = 64'(lo_root);
      hi_wide  = 64'(hi_root);
   end

   always_comb begin
      p_in = p_ff;   a_in = a_ff;   x_in = x_ff;   y_in = y_ff;
      e_in = e_ff;   r_in = r_ff;   d_in = d_ff;   c_in = c_ff;
      inv_in = inv_ff;  b_in = b_ff;  t_in = t_ff;  k_in = k_ff;
      g_in = g_ff;   f_in = f_ff;   s_in = s_ff;   i_in = i_ff;
      n_in = n_ff;   dst_in = dst_ff;
      has_in = has_ff;  small_in = small_ff;  large_in = large_ff;
      mm_start = 1'b0;
      mm_mode  = MM_MUL;
      mm_x     = x_ff;
      mm_y     = y_ff;

      if (csr_load) begin
         p_in = csr_wide[WIDTH-1:0];
      end

      unique case (cmd.op)
         DP_NOP: ;
         DP_LOAD:      a_in = req_wide[WIDTH-1:0];
         DP_REDUCE: begin
            mm_start = 1'b1; mm_mode = MM_RED; mm_x = '0; mm_y = a_ff; dst_in = DST_A;
         end
         DP_POW_EULER: begin x_in = a_ff; y_in = WIDTH'(1); e_in = pm1 >> 1; end
         DP_POW_Q3:    begin x_in = a_ff; y_in = WIDTH'(1); e_in = WIDTH'(pp1 >> 2); end
         DP_POW_Q5:    begin x_in = a_ff; y_in = WIDTH'(1); e_in = pm1 >> 2; end
         DP_POW_Q5R:   begin x_in = a_ff; y_in = WIDTH'(1); e_in = WIDTH'(pp3 >> 3); end
         DP_POW_Q5N: begin
            x_in = f_ff; y_in = WIDTH'(1); e_in = (p_ff - WIDTH'(5)) >> 3;
         end
         DP_POW_NR:    begin x_in = k_ff; y_in = WIDTH'(1); e_in = pm1 >> 1; end
         DP_POW_INV:   begin x_in = a_ff; y_in = WIDTH'(1); e_in = p_ff - WIDTH'(2); end
         DP_POW_C:     begin x_in = b_ff; y_in = WIDTH'(1); e_in = t_ff; end
         DP_POW_R:     begin x_in = a_ff; y_in = WIDTH'(1); e_in = WIDTH'(tp1 >> 1); end
         DP_MUL_YX: begin mm_start = 1'b1; mm_x = y_ff; mm_y = x_ff; dst_in = DST_Y; end
         DP_MUL_XX: begin
            mm_start = 1'b1; mm_x = x_ff; mm_y = x_ff; dst_in = DST_X; e_in = e_ff >> 1;
         end
         DP_MUL_A2: begin mm_start = 1'b1; mm_x = a_ff; mm_y = WIDTH'(2); dst_in = DST_G; end
         DP_MUL_A4: begin mm_start = 1'b1; mm_x = a_ff; mm_y = WIDTH'(4); dst_in = DST_F; end
         DP_MUL_GY: begin mm_start = 1'b1; mm_x = g_ff; mm_y = y_ff; dst_in = DST_R; end
         DP_MUL_RR: begin mm_start = 1'b1; mm_x = r_ff; mm_y = r_ff; dst_in = DST_D; end
         DP_MUL_DINV: begin mm_start = 1'b1; mm_x = d_ff; mm_y = inv_ff; dst_in = DST_D; end
         DP_MUL_DD: begin
            mm_start = 1'b1; mm_x = d_ff; mm_y = d_ff; dst_in = DST_D; n_in = n_ff - 1'b1;
         end
         DP_MUL_RC: begin mm_start = 1'b1; mm_x = r_ff; mm_y = c_ff; dst_in = DST_R; end
         DP_MUL_CC: begin
            mm_start = 1'b1; mm_x = c_ff; mm_y = c_ff; dst_in = DST_C; i_in = i_ff + 1'b1;
         end
         DP_MOV_YR:    r_in = y_ff;
         DP_MOV_YINV:  inv_in = y_ff;
         DP_MOV_YC:    c_in = y_ff;
         DP_SET_R0:    r_in = '0;
         DP_SET_R1:    r_in = WIDTH'(1);
         DP_SET_K2:    k_in = WIDTH'(2);
         DP_INC_K:     k_in = k_ff + 1'b1;
         DP_NR_FOUND:  begin b_in = k_ff; t_in = pm1; s_in = '0; end
         DP_T_SHIFT:   begin t_in = t_ff >> 1; s_in = s_ff + 1'b1; end
         DP_TS_START:  begin r_in = y_ff; i_in = SW'(1); end
         DP_SET_N:     n_in = s_ff - i_ff - 1'b1;
         DP_FIN_OK: begin
            has_in = 1'b1; small_in = lo_wide[DATA_W-1:0]; large_in = hi_wide[DATA_W-1:0];
         end
         DP_FIN_FAIL:  begin has_in = 1'b0; small_in = '0; large_in = '0; end
         default: ;
      endcase

      if (mm_done) begin
         case (dst_ff)
            DST_A: a_in = mm_result;
            DST_X: x_in = mm_result;
            DST_Y: y_in = mm_result;
            DST_G: g_in = mm_result;
            DST_F: f_in = mm_result;
            DST_R: r_in = mm_result;
            DST_D: d_in = mm_result;
            DST_C: c_in = mm_result;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= WIDTH'(3);
      end else begin
         p_ff <= p_in;
      end
      a_ff <= a_in;   x_ff <= x_in;   y_ff <= y_in;   e_ff <= e_in;
      r_ff <= r_in;   d_ff <= d_in;   c_ff <= c_in;   inv_ff <= inv_in;
      b_ff <= b_in;   t_ff <= t_in;   k_ff <= k_in;   g_ff <= g_in;
      f_ff <= f_in;   s_ff <= s_in;   i_ff <= i_in;   n_ff <= n_in;
      dst_ff <= dst_in;
      has_ff <= has_in;  small_ff <= small_in;  large_ff <= large_in;
   end

   msr_modmul #(.WIDTH(WIDTH)) u_modmul (
      .clock     (clock),
      .reset     (reset),
      .mm_start  (mm_start),
      .mm_mode   (mm_mode),
      .mm_x      (mm_x),
      .mm_y      (mm_y),
      .mm_m      (p_ff),
      .mm_done   (mm_done),
      .mm_result (mm_result)
   );

   always_comb begin
      status.mul_done = mm_done;
      status.p_zero   = (p_ff == '0);
      status.p_one    = (p_ff == WIDTH'(1));
      status.p_two    = (p_ff == WIDTH'(2));
      status.p_odd    = p_ff[0];
      status.p_mod4_3 = (p_ff[1:0] == 2'b11);
      status.p_mod8_5 = (p_ff[2:0] == 3'b101);
      status.a_zero   = (a_ff == '0);
      status.a_one    = (a_ff == WIDTH'(1));
      status.y_one    = (y_ff == WIDTH'(1));
      status.y_pm1    = (y_ff == pm1);
      status.d_pm1    = (d_ff == pm1);
      status.d_eq_a   = (d_ff == a_ff);
      status.e_zero   = (e_ff == '0);
      status.e_lsb    = e_ff[0];
      status.t_even   = !t_ff[0] && (t_ff != '0);
      status.n_zero   = (n_ff == '0);
      status.i_lt_s   = (i_ff < s_ff);
      status.k_over   = (k_ff > pm1) || (64'(k_ff) > NR_LIMIT);
   end

   assign out_has_root = has_ff;
   assign out_small    = small_ff;
   assign out_large    = large_ff;

endmodule

### rtl/msr_control.sv
// Controller: sequences reduction, exponentiations and the Tonelli-Shanks loop.
module msr_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output msr_pkg::dp_cmd_type     cmd,
   input  msr_pkg::dp_status_type  status
);
   import msr_pkg::*;

   state_type state_ff, state_in;
   state_type mul_ret_ff, mul_ret_in;
   state_type pow_ret_ff, pow_ret_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_ret_ff   <= ST_IDLE;
         pow_ret_ff   <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_ret_ff   <= mul_ret_in;
         pow_ret_ff   <= pow_ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_tready;
      state_in     = state_ff;
      mul_ret_in   = mul_ret_ff;
      pow_ret_in   = pow_ret_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd.op       = DP_NOP;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = DP_LOAD; state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.p_zero) begin
               state_in = ST_FIN_FAIL;
            end else begin
               cmd.op = DP_REDUCE; mul_ret_in = ST_DISPATCH; state_in = ST_MUL_WAIT;
            end
         end
         ST_DISPATCH: begin
            if (status.p_one) begin
               cmd.op = DP_SET_R0; state_in = ST_FIN_OK;
            end else if (status.p_two) begin
               if (status.a_one) begin
                  cmd.op = DP_SET_R1; state_in = ST_FIN_OK;
               end else begin
                  state_in = ST_FIN_FAIL;
               end
            end else if (status.a_zero) begin
               cmd.op = DP_SET_R0; state_in = ST_FIN_OK;
            end else if (!status.p_odd) begin
               state_in = ST_FIN_FAIL;
            end else begin
               cmd.op = DP_POW_EULER; pow_ret_in = ST_EULER_CHK; state_in = ST_POW;
            end
         end
         ST_EULER_CHK: begin
            if (!status.y_one) begin
               state_in = ST_FIN_FAIL;
            end else if (status.p_mod4_3) begin
               cmd.op = DP_POW_Q3; pow_ret_in = ST_Q3_DONE; state_in = ST_POW;
            end else if (status.p_mod8_5) begin
               cmd.op = DP_POW_Q5; pow_ret_in = ST_Q5_CHK; state_in = ST_POW;
            end else begin
               cmd.op = DP_SET_K2; state_in = ST_NR_TEST;
            end
         end
         ST_Q3_DONE: begin
            cmd.op = DP_MOV_YR; state_in = ST_VERIFY;
         end
         ST_Q5_CHK: begin
            if (status.y_one) begin
               cmd.op = DP_POW_Q5R; pow_ret_in = ST_Q3_DONE; state_in = ST_POW;
            end else if (status.y_pm1) begin
               cmd.op = DP_MUL_A2; mul_ret_in = ST_Q5N_A4; state_in = ST_MUL_WAIT;
            end else begin
               cmd.op = DP_SET_K2; state_in = ST_NR_TEST;
            end
         end
         ST_Q5N_A4: begin
            cmd.op = DP_MUL_A4; mul_ret_in = ST_Q5N_POW; state_in = ST_MUL_WAIT;
         end
         ST_Q5N_POW: begin
            cmd.op = DP_POW_Q5N; pow_ret_in = ST_Q5N_MUL; state_in = ST_POW;
         end
         ST_Q5N_MUL: begin
            cmd.op = DP_MUL_GY; mul_ret_in = ST_VERIFY; state_in = ST_MUL_WAIT;
         end
         ST_NR_TEST: begin
            if (status.k_over) begin
               state_in = ST_FIN_FAIL;
            end else begin
               cmd.op = DP_POW_NR; pow_ret_in = ST_NR_CHK; state_in = ST_POW;
            end
         end
         ST_NR_CHK: begin
            if (status.y_pm1) begin
               cmd.op = DP_NR_FOUND; state_in = ST_TS_SHIFT;
            end else begin
               cmd.op = DP_INC_K; state_in = ST_NR_TEST;
            end
         end
         ST_TS_SHIFT: begin
            if (status.t_even) begin
               cmd.op = DP_T_SHIFT;
            end else begin
               cmd.op = DP_POW_INV; pow_ret_in = ST_TS_C; state_in = ST_POW;
            end
         end
         ST_TS_C:  begin cmd.op = DP_MOV_YINV; state_in = ST_TS_C2; end
         ST_TS_C2: begin cmd.op = DP_POW_C; pow_ret_in = ST_TS_R; state_in = ST_POW; end
         ST_TS_R:  begin cmd.op = DP_MOV_YC; state_in = ST_TS_R2; end
         ST_TS_R2: begin cmd.op = DP_POW_R; pow_ret_in = ST_TS_LOOP0; state_in = ST_POW; end
         ST_TS_LOOP0: begin cmd.op = DP_TS_START; state_in = ST_TS_LOOP; end
         ST_TS_LOOP: begin
            if (!status.i_lt_s) begin
               state_in = ST_VERIFY;
            end else begin
               cmd.op = DP_MUL_RR; mul_ret_in = ST_TS_DINV; state_in = ST_MUL_WAIT;
            end
         end
         ST_TS_DINV: begin
            cmd.op = DP_MUL_DINV; mul_ret_in = ST_TS_CNT; state_in = ST_MUL_WAIT;
         end
         ST_TS_CNT: begin cmd.op = DP_SET_N; state_in = ST_TS_SQ; end
         ST_TS_SQ: begin
            if (status.n_zero) begin
               state_in = ST_TS_CHK;
            end else begin
               cmd.op = DP_MUL_DD; mul_ret_in = ST_TS_SQ; state_in = ST_MUL_WAIT;
            end
         end
         ST_TS_CHK: begin
            if (status.d_pm1) begin
               cmd.op = DP_MUL_RC; mul_ret_in = ST_TS_CC; state_in = ST_MUL_WAIT;
            end else begin
               state_in = ST_TS_CC;
            end
         end
         ST_TS_CC: begin
            cmd.op = DP_MUL_CC; mul_ret_in = ST_TS_LOOP; state_in = ST_MUL_WAIT;
         end
         ST_VERIFY: begin
            cmd.op = DP_MUL_RR; mul_ret_in = ST_VERIFY_CHK; state_in = ST_MUL_WAIT;
         end
         ST_VERIFY_CHK: begin
            state_in = status.d_eq_a ? ST_FIN_OK : ST_FIN_FAIL;
         end
         ST_POW: begin
            if (status.e_zero) begin
               state_in = pow_ret_ff;
            end else if (status.e_lsb) begin
               cmd.op = DP_MUL_YX; mul_ret_in = ST_POW_XX; state_in = ST_MUL_WAIT;
            end else begin
               state_in = ST_POW_XX;
            end
         end
         ST_POW_XX: begin
            cmd.op = DP_MUL_XX; mul_ret_in = ST_POW; state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (status.mul_done) begin
               state_in = mul_ret_ff;
            end
         end
         ST_FIN_OK: begin
            if (slot_free) begin
               cmd.op = DP_FIN_OK; rsp_valid_in = 1'b1; state_in = ST_IDLE;
            end
         end
         ST_FIN_FAIL: begin
            if (slot_free) begin
               cmd.op = DP_FIN_FAIL; rsp_valid_in = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == ST_MUL_WAIT)) else $error("multiply done outside wait");
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_START)) else $error("accept did not start");
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_FIN_OK || cmd.op == DP_FIN_FAIL) |=> rsp_valid_ff)
      else $error("result written without valid");

endmodule

### rtl/modular_square_root_prime.sv
// Modular square root over a configured prime modulus: top level.
// An exponentiation takes up to 2*WIDTH multiplies; a 3 mod 4 prime needs two
// exponentiations, and Tonelli-Shanks adds one per non-residue candidate plus three
// more and about s^2/2 multiplies.
// One transaction at a time; the next is taken once the result is registered.
// Reset (synchronous, active high): modulus 3, both channels empty, controller idle.
module modular_square_root_prime #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = value[31:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: tdata = root_small[31:0], root_large[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // response: tuser = has_root[0]
   output logic        rsp_tuser,
   // configuration: prime_modulus
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import msr_pkg::*;

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [DATA_W-1:0]   root_small;
   logic [DATA_W-1:0]   root_large;
   logic                has_root;

   // Modulus writes are taken any cycle; the user must issue them only while idle, as the block does not enforce it.
   assign csr_ready = 1'b1;

   msr_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   msr_datapath #(.WIDTH(WIDTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data     (req_tdata),
      .csr_load     (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .out_has_root (has_root),
      .out_small    (root_small),
      .out_large    (root_large)
   );

   // Result register lives in the datapath; valid is owned by the controller.
   assign rsp_tdata = {root_large, root_small};
   assign rsp_tuser = has_root;

endmodule

### dv/modular_square_root_prime_tb.sv
// Self-checking testbench for the modular square root block.
`timescale 1ns / 1ps

module modular_square_root_prime_tb;
   import msr_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;

   typedef struct packed {
      logic        has_root;
      logic [31:0] root_small;
      logic [31:0] root_large;
   } root_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   // predictor state: shadow copy of the modulus register
   logic [31:0]     modulus_shadow;
   root_result_type pending_roots[$];
   int              error_count = 0;
   int              result_count = 0;
   int              idle_cycles = 0;
   bit              send_gaps = 1'b1;
   bit              recv_gaps = 1'b1;
   int              hold_off = 0;

   always #5 clock = ~clock;

   modular_square_root_prime u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // ---------------- predictor ----------------
   function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [63:0] acc;
      acc = 0;
      for (int b = 31; b >= 0; b--) begin
         acc = acc << 1;
         if (acc >= m) acc -= m;
         if (y[b]) begin
            acc += x;
            if (acc >= m) acc -= m;
         end
      end
      return acc;
   endfunction

   function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
      logic [63:0] res, b;
      res = 1 % m;
      b = base % m;
      while (e != 0) begin
         if (e[0]) res = mod_mul(res, b, m);
         b = mod_mul(b, b, m);
         e = e >> 1;
      end
      return res;
   endfunction

   // candidate root of nonzero a modulo odd p; returns 0 when none is found
   function automatic bit odd_prime_root(logic [63:0] a, logic [63:0] p,
                                         output logic [63:0] r);
      logic [63:0] t, s, b, c, inv, d, lim, two_a, four_a;
      bit found;
      found = 0;
      r = 0;
      if (mod_pow(a, (p - 1) >> 1, p) != 1) return 0;
      if (p[1:0] == 2'b11) begin
         r = mod_pow(a, (p + 1) >> 2, p);
         return 1;
      end
      if (p[2:0] == 3'b101) begin
         d = mod_pow(a, (p - 1) >> 2, p);
         if (d == 1) begin
            r = mod_pow(a, (p + 3) >> 3, p);
            return 1;
         end
         if (d == p - 1) begin
            two_a = mod_mul(a, 2 % p, p);
            four_a = mod_mul(a, 4 % p, p);
            r = mod_mul(two_a, mod_pow(four_a, (p - 5) >> 3, p), p);
            return 1;
         end
      end
      lim = (p - 1 < NR_LIMIT) ? p - 1 : NR_LIMIT;
      b = 0;
      for (logic [63:0] k = 2; k <= lim; k++) begin
         if (mod_pow(k, (p - 1) >> 1, p) == p - 1) begin
            b = k;
            found = 1;
            break;
         end
      end
      if (!found) return 0;
      t = p - 1;
      s = 0;
      while (t != 0 && !t[0]) begin
         t = t >> 1;
         s++;
      end
      inv = mod_pow(a, p - 2, p);
      c = mod_pow(b, t, p);
      r = mod_pow(a, (t + 1) >> 1, p);
      for (logic [63:0] i = 1; i + 1 <= s; i++) begin
         d = mod_mul(mod_mul(r, r, p), inv, p);
         for (logic [63:0] k = 0; k + i + 1 < s; k++) d = mod_mul(d, d, p);
         if (d == p - 1) r = mod_mul(r, c, p);
         c = mod_mul(c, c, p);
      end
      return 1;
   endfunction

   function automatic root_result_type predict_roots(logic [31:0] value);
      root_result_type res;
      logic [63:0] p, a, r, other;
      bit ok;
      res = '0;
      p = 64'(modulus_shadow);
      r = 0;
      ok = 0;
      if (p == 0) return res;
      a = 64'(value) % p;
      if (p == 1) ok = 1;
      else if (p == 2) begin
         ok = (a == 1);
         r = 1;
      end else if (a == 0) ok = 1;
      else if (p[0]) begin
         ok = odd_prime_root(a, p, r);
         if (ok && mod_mul(r, r, p) != a) ok = 0;
      end
      if (ok) begin
         other = (r == 0) ? 0 : p - r;
         res.has_root = 1'b1;
         res.root_small = 32'((r < other) ? r : other);
         res.root_large = 32'((r < other) ? other : r);
      end
      return res;
   endfunction

   // ---------------- driving ----------------
   // valid stays high between back-to-back transactions; a gap drops it first
   task automatic random_gap();
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   task automatic send_value(logic [31:0] value);
      random_gap();
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      pending_roots.insert(pending_roots.size(), predict_roots(value));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_roots.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_modulus(logic [31:0] p);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= p;
      do @(posedge clock); while (!csr_ready);
      modulus_shadow = p;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      root_result_type want;
      if (reset) idle_cycles <= 0;
      else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (pending_roots.size() == 0) report_mismatch("unexpected transaction", 0, 0);
            else begin
               want = pending_roots.pop_front();
               if (rsp_tuser !== want.has_root)
                  report_mismatch("has_root", 32'(rsp_tuser), 32'(want.has_root));
               if (rsp_tdata[31:0] !== want.root_small)
                  report_mismatch("root_small", rsp_tdata[31:0], want.root_small);
               if (rsp_tdata[63:32] !== want.root_large)
                  report_mismatch("root_large", rsp_tdata[63:32], want.root_large);
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else if (recv_gaps && $urandom_range(0, 7) == 0)
         rsp_tready <= 1'b0;
      else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_special_moduli();
      write_modulus(32'd0);
      send_value(32'd5);
      write_modulus(32'd1);
      send_value(32'hFFFF_FFFF);
      write_modulus(32'd2);
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
   endtask

   task automatic test_directed_primes();
      // 3 mod 4, 5 mod 8, Tonelli-Shanks (17, 97, 65537), largest 32-bit prime
      logic [31:0] primes[6] = '{32'd3, 32'd13, 32'd17, 32'd97, 32'd65537, 32'hFFFF_FFFB};
      foreach (primes[i]) begin
         write_modulus(primes[i]);
         send_value(32'd0);
         send_value(primes[i]);
         send_value(32'd4);
         send_value(32'hFFFF_FFFF);
      end
   endtask

   task automatic test_composite();
      write_modulus(32'd15);
      send_value(32'd4);
      send_value(32'd7);
      write_modulus(32'd33);   // 1 mod 8, composite
      send_value(32'd4);
   endtask

   task automatic test_random_values();
      logic [31:0] primes[8] = '{32'd7, 32'd41, 32'd257, 32'd7681, 32'd40961,
                                 32'd2147483647, 32'd998244353, 32'hFFFF_FFFB};
      for (int n = 0; n < 110; n++) begin
         if (n % 19 == 0) write_modulus(primes[$urandom_range(0, 7)]);
         // no idling after the last modulus change
         if (n == 95) begin
            send_gaps = 0;
            recv_gaps = 0;
         end
         if ($urandom_range(0, 3) == 0) send_value($urandom_range(0, 64));
         else send_value($urandom());
      end
   endtask

   task automatic test_backpressure();
      write_modulus(32'd7);
      @(negedge clock);
      hold_off = 3000;
      for (int n = 0; n < 6; n++) send_value($urandom());
   endtask

   initial begin
      modulus_shadow = 32'd3;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_value(32'd2);   // reset modulus of three, non-residue
      test_special_moduli();
      test_directed_primes();
      test_composite();
      test_backpressure();
      test_random_values();
      drain();
      $display("covered special moduli, 3 mod 4, 5 mod 8 and Tonelli-Shanks primes,");
      $display("composites, stalls and a long output hold-off: %0d results", result_count);
      if (error_count == 0 && pending_roots.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
